@@ rtl/clamped_velocity_integrator_core_macros.svh @@
// Assertion macros for the clamped velocity integrator.
// Included by the top level. It needs no package and no other file.
`ifndef CLAMPED_VELOCITY_INTEGRATOR_CORE_MACROS_SVH
`define CLAMPED_VELOCITY_INTEGRATOR_CORE_MACROS_SVH

// The condition implies the property in the same cycle.
`define CVI_ASSERT_NOW(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("clamped velocity integrator check failed");

// The condition implies the property in the next cycle.
`define CVI_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("clamped velocity integrator check failed");

`endif

@@ rtl/cvi_pkg.sv @@
// Shared types, widths, register codes and helpers for the clamped velocity integrator.
// Used by cvi_clamp, cvi_euler and the top level; depends on nothing.
package cvi_pkg;

   // Field and datapath widths.
   localparam int WORD_W  = 32;
   localparam int LIMIT_W = 31;
   localparam int SQ_W    = 2 * WORD_W;
   localparam int PROD_W  = WORD_W + LIMIT_W;
   localparam int L2_W    = 2 * LIMIT_W;
   localparam int FRAC_W  = 16;
   localparam int SH_W    = PROD_W - FRAC_W;
   localparam int SUM_W   = SH_W + 1;

   // Pipeline depths: the root and the divide retire two bits per stage.
   localparam int SQRT_STAGES  = WORD_W / 2;
   localparam int DIV_STAGES   = WORD_W / 2;
   localparam int CLAMP_STAGES = 2 + SQRT_STAGES + DIV_STAGES + 1;
   localparam int EULER_STAGES = 2;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef word_type [2:0] vec3_type;
   typedef logic [LIMIT_W-1:0] limit_type;
   typedef logic [1:0] csr_addr_type;

   // Register indexes.
   localparam csr_addr_type CSR_TIME_STEP   = 2'd0;
   localparam csr_addr_type CSR_ACCEL_LIMIT = 2'd1;
   localparam csr_addr_type CSR_SPEED_LIMIT = 2'd2;

   localparam limit_type TIME_STEP_RESET = 31'd655;
   localparam limit_type LIMIT_RESET     = 31'h7FFF_FFFF;

   localparam word_type WORD_MAX = 32'sh7FFF_FFFF;
   localparam word_type WORD_MIN = 32'sh8000_0000;

   typedef struct packed {
      word_type acc_x;
      word_type acc_y;
      word_type acc_z;
      word_type vel_x;
      word_type vel_y;
      word_type vel_z;
   } req_type;

   typedef struct packed {
      word_type new_vel_x;
      word_type new_vel_y;
      word_type new_vel_z;
   } rsp_type;

   // Magnitude of a signed word; the most negative value maps to 2^31.
   function automatic logic [WORD_W-1:0] word_mag(word_type c);
      logic [WORD_W-1:0] u;
      u = c;
      return c[WORD_W-1] ? (~u + 1'b1) : u;
   endfunction

endpackage

@@ rtl/cvi_clamp.sv @@
// Pipelined length clamp: scales a 3-vector down to a limit when its length exceeds it.
// Depends on cvi_pkg for widths, stage counts and the magnitude helper.
module cvi_clamp (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  cvi_pkg::vec3_type   in_vec,
   input  cvi_pkg::vec3_type   in_side,
   input  cvi_pkg::limit_type  limit,
   output logic                out_valid,
   output cvi_pkg::vec3_type   out_vec,
   output cvi_pkg::vec3_type   out_side
);

   logic [cvi_pkg::CLAMP_STAGES-1:0] vld_ff, vld_in;

   // First stage: squares, limit squared and magnitude times limit.
   logic [2:0][cvi_pkg::WORD_W-1:0] a_mag;
   logic [2:0][cvi_pkg::SQ_W-1:0]   a_sq_in, a_sq_ff;
   logic [2:0][cvi_pkg::PROD_W-1:0] a_prod_in, a_prod_ff;
   logic [cvi_pkg::L2_W-1:0]        a_l2_in, a_l2_ff;
   cvi_pkg::vec3_type               a_vec_ff, a_side_ff;

   // Second stage: sum of squares.
   logic [cvi_pkg::SQ_W-1:0]        b_s_in, b_s_ff;
   logic [cvi_pkg::L2_W-1:0]        b_l2_ff;
   logic [2:0][cvi_pkg::PROD_W-1:0] b_prod_ff;
   cvi_pkg::vec3_type               b_vec_ff, b_side_ff;

   // Square root stages.
   logic [cvi_pkg::SQ_W-1:0]        q_rem_in  [cvi_pkg::SQRT_STAGES];
   logic [cvi_pkg::SQ_W-1:0]        q_rem_ff  [cvi_pkg::SQRT_STAGES];
   logic [cvi_pkg::WORD_W-1:0]      q_root_in [cvi_pkg::SQRT_STAGES];
   logic [cvi_pkg::WORD_W-1:0]      q_root_ff [cvi_pkg::SQRT_STAGES];
   logic                            q_need_in [cvi_pkg::SQRT_STAGES];
   logic                            q_need_ff [cvi_pkg::SQRT_STAGES];
   logic [2:0][cvi_pkg::PROD_W-1:0] q_prod_in [cvi_pkg::SQRT_STAGES];
   logic [2:0][cvi_pkg::PROD_W-1:0] q_prod_ff [cvi_pkg::SQRT_STAGES];
   cvi_pkg::vec3_type               q_vec_in  [cvi_pkg::SQRT_STAGES];
   cvi_pkg::vec3_type               q_vec_ff  [cvi_pkg::SQRT_STAGES];
   cvi_pkg::vec3_type               q_side_in [cvi_pkg::SQRT_STAGES];
   cvi_pkg::vec3_type               q_side_ff [cvi_pkg::SQRT_STAGES];

   // Divide stages, one restoring divider per component.
   logic [cvi_pkg::SQ_W-1:0]   d_rem_in  [cvi_pkg::DIV_STAGES][3];
   logic [cvi_pkg::SQ_W-1:0]   d_rem_ff  [cvi_pkg::DIV_STAGES][3];
   logic [cvi_pkg::WORD_W-1:0] d_quo_in  [cvi_pkg::DIV_STAGES][3];
   logic [cvi_pkg::WORD_W-1:0] d_quo_ff  [cvi_pkg::DIV_STAGES][3];
   logic [cvi_pkg::WORD_W-1:0] d_div_in  [cvi_pkg::DIV_STAGES];
   logic [cvi_pkg::WORD_W-1:0] d_div_ff  [cvi_pkg::DIV_STAGES];
   logic                       d_need_in [cvi_pkg::DIV_STAGES];
   logic                       d_need_ff [cvi_pkg::DIV_STAGES];
   cvi_pkg::vec3_type          d_vec_in  [cvi_pkg::DIV_STAGES];
   cvi_pkg::vec3_type          d_vec_ff  [cvi_pkg::DIV_STAGES];
   cvi_pkg::vec3_type          d_side_in [cvi_pkg::DIV_STAGES];
   cvi_pkg::vec3_type          d_side_ff [cvi_pkg::DIV_STAGES];

   // Final stage: sign restore and select.
   logic [cvi_pkg::WORD_W-1:0] f_quo;
   cvi_pkg::vec3_type          f_vec_in, f_vec_ff, f_side_ff;

   // Valid bits shift along with the data.
   assign vld_in = {vld_ff[cvi_pkg::CLAMP_STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Products of the first stage.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_mag[i]     = cvi_pkg::word_mag(in_vec[i]);
         a_sq_in[i]   = cvi_pkg::SQ_W'(a_mag[i]) * cvi_pkg::SQ_W'(a_mag[i]);
         a_prod_in[i] = cvi_pkg::PROD_W'(a_mag[i]) * cvi_pkg::PROD_W'(limit);
      end
      a_l2_in = cvi_pkg::L2_W'(limit) * cvi_pkg::L2_W'(limit);
   end

   // Sum of the three squares cannot overflow 64 bits.
   assign b_s_in = a_sq_ff[0] + a_sq_ff[1] + a_sq_ff[2];

   // Floor square root, two result bits per stage.
   for (genvar k = 0; k < cvi_pkg::SQRT_STAGES; k++) begin : g_sqrt
      localparam int HI = cvi_pkg::WORD_W - 1 - 2 * k;
      localparam int LO = HI - 1;
      logic [cvi_pkg::SQ_W-1:0]   rem_src, rem_mid, rem_out, try_hi, try_lo;
      logic [cvi_pkg::WORD_W-1:0] root_src, root_mid, root_out;

      if (k == 0) begin : g_head
         assign rem_src      = b_s_ff;
         assign root_src     = '0;
         assign q_need_in[k] = b_s_ff > cvi_pkg::SQ_W'(b_l2_ff);
         assign q_prod_in[k] = b_prod_ff;
         assign q_vec_in[k]  = b_vec_ff;
         assign q_side_in[k] = b_side_ff;
      end else begin : g_body
         assign rem_src      = q_rem_ff[k-1];
         assign root_src     = q_root_ff[k-1];
         assign q_need_in[k] = q_need_ff[k-1];
         assign q_prod_in[k] = q_prod_ff[k-1];
         assign q_vec_in[k]  = q_vec_ff[k-1];
         assign q_side_in[k] = q_side_ff[k-1];
      end

      // Each step tests (root + 2^i)^2 - root^2 against the remainder.
      always_comb begin
         try_hi = (cvi_pkg::SQ_W'(root_src) << (HI + 1)) | (cvi_pkg::SQ_W'(1) << (2 * HI));
         if (rem_src >= try_hi) begin
            rem_mid  = rem_src - try_hi;
            root_mid = root_src | (cvi_pkg::WORD_W'(1) << HI);
         end else begin
            rem_mid  = rem_src;
            root_mid = root_src;
         end
         try_lo = (cvi_pkg::SQ_W'(root_mid) << (LO + 1)) | (cvi_pkg::SQ_W'(1) << (2 * LO));
         if (rem_mid >= try_lo) begin
            rem_out  = rem_mid - try_lo;
            root_out = root_mid | (cvi_pkg::WORD_W'(1) << LO);
         end else begin
            rem_out  = rem_mid;
            root_out = root_mid;
         end
      end

      assign q_rem_in[k]  = rem_out;
      assign q_root_in[k] = root_out;
   end

   // Restoring divide of magnitude times limit by the root, two quotient bits per stage.
   for (genvar k = 0; k < cvi_pkg::DIV_STAGES; k++) begin : g_div
      localparam int HI = cvi_pkg::WORD_W - 1 - 2 * k;
      localparam int LO = HI - 1;
      logic [cvi_pkg::WORD_W-1:0] div_src;

      if (k == 0) begin : g_head
         assign div_src      = q_root_ff[cvi_pkg::SQRT_STAGES-1];
         assign d_need_in[k] = q_need_ff[cvi_pkg::SQRT_STAGES-1];
         assign d_vec_in[k]  = q_vec_ff[cvi_pkg::SQRT_STAGES-1];
         assign d_side_in[k] = q_side_ff[cvi_pkg::SQRT_STAGES-1];
      end else begin : g_body
         assign div_src      = d_div_ff[k-1];
         assign d_need_in[k] = d_need_ff[k-1];
         assign d_vec_in[k]  = d_vec_ff[k-1];
         assign d_side_in[k] = d_side_ff[k-1];
      end
      assign d_div_in[k] = div_src;

      for (genvar i = 0; i < 3; i++) begin : g_lane
         logic [cvi_pkg::SQ_W-1:0]   rem_src, rem_mid, rem_out, sub_hi, sub_lo;
         logic [cvi_pkg::WORD_W-1:0] quo_src, quo_mid, quo_out;

         if (k == 0) begin : g_head
            assign rem_src = cvi_pkg::SQ_W'(q_prod_ff[cvi_pkg::SQRT_STAGES-1][i]);
            assign quo_src = '0;
         end else begin : g_body
            assign rem_src = d_rem_ff[k-1][i];
            assign quo_src = d_quo_ff[k-1][i];
         end

         always_comb begin
            sub_hi = cvi_pkg::SQ_W'(div_src) << HI;
            if (rem_src >= sub_hi) begin
               rem_mid = rem_src - sub_hi;
               quo_mid = quo_src | (cvi_pkg::WORD_W'(1) << HI);
            end else begin
               rem_mid = rem_src;
               quo_mid = quo_src;
            end
            sub_lo = cvi_pkg::SQ_W'(div_src) << LO;
            if (rem_mid >= sub_lo) begin
               rem_out = rem_mid - sub_lo;
               quo_out = quo_mid | (cvi_pkg::WORD_W'(1) << LO);
            end else begin
               rem_out = rem_mid;
               quo_out = quo_mid;
            end
         end

         assign d_rem_in[k][i] = rem_out;
         assign d_quo_in[k][i] = quo_out;
      end
   end

   // A clamped component takes the quotient with its original sign.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f_quo = d_quo_ff[cvi_pkg::DIV_STAGES-1][i];
         if (d_need_ff[cvi_pkg::DIV_STAGES-1]) begin
            f_vec_in[i] = d_vec_ff[cvi_pkg::DIV_STAGES-1][i][cvi_pkg::WORD_W-1]
               ? -cvi_pkg::word_type'(f_quo) : cvi_pkg::word_type'(f_quo);
         end else begin
            f_vec_in[i] = d_vec_ff[cvi_pkg::DIV_STAGES-1][i];
         end
      end
   end

   // Payload registers of all stages advance together.
   always_ff @(posedge clock) begin
      if (en) begin
         a_vec_ff  <= in_vec;
         a_side_ff <= in_side;
         a_sq_ff   <= a_sq_in;
         a_prod_ff <= a_prod_in;
         a_l2_ff   <= a_l2_in;
         b_s_ff    <= b_s_in;
         b_l2_ff   <= a_l2_ff;
         b_prod_ff <= a_prod_ff;
         b_vec_ff  <= a_vec_ff;
         b_side_ff <= a_side_ff;
         q_rem_ff  <= q_rem_in;
         q_root_ff <= q_root_in;
         q_need_ff <= q_need_in;
         q_prod_ff <= q_prod_in;
         q_vec_ff  <= q_vec_in;
         q_side_ff <= q_side_in;
         d_rem_ff  <= d_rem_in;
         d_quo_ff  <= d_quo_in;
         d_div_ff  <= d_div_in;
         d_need_ff <= d_need_in;
         d_vec_ff  <= d_vec_in;
         d_side_ff <= d_side_in;
         f_vec_ff  <= f_vec_in;
         f_side_ff <= d_side_ff[cvi_pkg::DIV_STAGES-1];
      end
   end

   assign out_valid = vld_ff[cvi_pkg::CLAMP_STAGES-1];
   assign out_vec   = f_vec_ff;
   assign out_side  = f_side_ff;

endmodule

@@ rtl/cvi_euler.sv @@
// Euler velocity step: v + floor(a * dt / 2^16), saturated per component, in two stages.
// Depends on cvi_pkg for widths and saturation limits.
module cvi_euler (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  cvi_pkg::vec3_type   in_acc,
   input  cvi_pkg::vec3_type   in_vel,
   input  cvi_pkg::limit_type  time_step,
   output logic                out_valid,
   output cvi_pkg::vec3_type   out_vel
);

   logic [cvi_pkg::EULER_STAGES-1:0] vld_ff, vld_in;

   logic signed [cvi_pkg::WORD_W:0]   ts_s;
   logic signed [cvi_pkg::SQ_W-1:0]   m_full [3];
   logic signed [cvi_pkg::PROD_W-1:0] m_prod_in [3];
   logic signed [cvi_pkg::PROD_W-1:0] m_prod_ff [3];
   cvi_pkg::vec3_type                 m_vel_ff;

   logic signed [cvi_pkg::SH_W-1:0]  s_sh  [3];
   logic signed [cvi_pkg::SUM_W-1:0] s_sum [3];
   cvi_pkg::vec3_type                s_vel_in, s_vel_ff;

   assign vld_in = {vld_ff[cvi_pkg::EULER_STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Multiply stage: signed acceleration times unsigned time step.
   assign ts_s = {2'b00, time_step};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m_full[i]    = in_acc[i] * ts_s;
         m_prod_in[i] = m_full[i][cvi_pkg::PROD_W-1:0];
      end
   end

   // Add stage: arithmetic shift rounds toward minus infinity, then saturate.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s_sh[i]  = m_prod_ff[i][cvi_pkg::PROD_W-1:cvi_pkg::FRAC_W];
         s_sum[i] = cvi_pkg::SUM_W'(m_vel_ff[i]) + cvi_pkg::SUM_W'(s_sh[i]);
         if (&s_sum[i][cvi_pkg::SUM_W-1:cvi_pkg::WORD_W-1] ||
             ~|s_sum[i][cvi_pkg::SUM_W-1:cvi_pkg::WORD_W-1]) begin
            s_vel_in[i] = s_sum[i][cvi_pkg::WORD_W-1:0];
         end else if (s_sum[i][cvi_pkg::SUM_W-1]) begin
            s_vel_in[i] = cvi_pkg::WORD_MIN;
         end else begin
            s_vel_in[i] = cvi_pkg::WORD_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_prod_ff <= m_prod_in;
         m_vel_ff  <= in_vel;
         s_vel_ff  <= s_vel_in;
      end
   end

   assign out_valid = vld_ff[cvi_pkg::EULER_STAGES-1];
   assign out_vel   = s_vel_ff;

endmodule

@@ rtl/clamped_velocity_integrator_core.sv @@
// Clamped velocity integrator: acceleration clamp, Euler step, speed clamp.
// An accepted word passes both clamps, the Euler step and the output register on its way to rsp.
// Throughput: one word per cycle while req_ready is high; clamp root/divide: two bits per stage.
// A stalled output holds one result plus one in a skid register; req_ready drops when both fill.
// Synchronous reset clears all valid bits and restores the register reset values.
// Depends on cvi_pkg, cvi_clamp, cvi_euler and the assertion macro header.
`include "clamped_velocity_integrator_core_macros.svh"

module clamped_velocity_integrator_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cvi_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cvi_pkg::rsp_type       rsp_data,
   input  logic                   csr_we,
   input  cvi_pkg::csr_addr_type  csr_addr,
   input  cvi_pkg::limit_type     csr_wdata
);

   cvi_pkg::limit_type time_step_ff, accel_limit_ff, speed_limit_ff;

   logic              pipe_en;
   cvi_pkg::vec3_type req_acc, req_vel;
   logic              c1_valid, eu_valid, c2_valid;
   cvi_pkg::vec3_type c1_vec, c1_side, eu_vel, c2_vec;
   cvi_pkg::rsp_type  c2_data;

   logic             arriving, out_free;
   logic             out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;
   cvi_pkg::rsp_type out_data_ff, out_data_in, skid_data_ff, skid_data_in;
   logic             rsp_in_bound;

   // Configuration registers; writes to an unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff   <= cvi_pkg::TIME_STEP_RESET;
         accel_limit_ff <= cvi_pkg::LIMIT_RESET;
         speed_limit_ff <= cvi_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            cvi_pkg::CSR_TIME_STEP:   time_step_ff   <= csr_wdata;
            cvi_pkg::CSR_ACCEL_LIMIT: accel_limit_ff <= csr_wdata;
            cvi_pkg::CSR_SPEED_LIMIT: speed_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole pipeline advances while the skid register is empty.
   assign pipe_en   = !skid_vld_ff;
   assign req_ready = pipe_en;

   assign req_acc = {req_data.acc_z, req_data.acc_y, req_data.acc_x};
   assign req_vel = {req_data.vel_z, req_data.vel_y, req_data.vel_x};

   cvi_clamp u_accel_clamp (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_valid),
      .in_vec    (req_acc),
      .in_side   (req_vel),
      .limit     (accel_limit_ff),
      .out_valid (c1_valid),
      .out_vec   (c1_vec),
      .out_side  (c1_side)
   );

   cvi_euler u_euler (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (c1_valid),
      .in_acc    (c1_vec),
      .in_vel    (c1_side),
      .time_step (time_step_ff),
      .out_valid (eu_valid),
      .out_vel   (eu_vel)
   );

   cvi_clamp u_speed_clamp (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (eu_valid),
      .in_vec    (eu_vel),
      .in_side   ('0),
      .limit     (speed_limit_ff),
      .out_valid (c2_valid),
      .out_vec   (c2_vec),
      .out_side  ()
   );

   assign c2_data = '{new_vel_x: c2_vec[0], new_vel_y: c2_vec[1], new_vel_z: c2_vec[2]};

   // Output register with a one-word skid behind it.
   assign arriving = pipe_en && c2_valid;
   assign out_free = !out_vld_ff || rsp_ready;

   always_comb begin
      out_vld_in   = out_vld_ff;
      out_data_in  = out_data_ff;
      skid_vld_in  = skid_vld_ff;
      skid_data_in = skid_data_ff;
      if (out_free) begin
         if (skid_vld_ff) begin
            out_vld_in  = 1'b1;
            out_data_in = skid_data_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in  = arriving;
            out_data_in = c2_data;
         end
      end else if (arriving) begin
         skid_vld_in  = 1'b1;
         skid_data_in = c2_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   // Every result component stays within the speed limit.
   assign rsp_in_bound =
      (cvi_pkg::word_mag(out_data_ff.new_vel_x) <= {1'b0, speed_limit_ff}) &&
      (cvi_pkg::word_mag(out_data_ff.new_vel_y) <= {1'b0, speed_limit_ff}) &&
      (cvi_pkg::word_mag(out_data_ff.new_vel_z) <= {1'b0, speed_limit_ff});

   `CVI_ASSERT_NOW(a_stall_needs_output, clock, reset, !req_ready, rsp_valid)
   `CVI_ASSERT_NEXT(a_take_frees_skid, clock, reset, rsp_valid && rsp_ready, req_ready)
   `CVI_ASSERT_NOW(a_speed_bound, clock, reset, rsp_valid, rsp_in_bound)

endmodule
